[rtl/fsdr_pkg.sv]
// Shared types and constants for the frame topic dispatcher with speed sample ring.
package fsdr_pkg;

  // Frame store length: a frame closes when it holds this many bytes
  localparam int FRAME_BYTES = 254;

  // Sample entries built per speed frame, eight bytes each, from bytes 1..80
  localparam int NUM_ROWS   = 10;
  localparam int ROW_W      = 4;
  localparam int ROW_BYTES  = 8;
  localparam int SPAN_BYTES = NUM_ROWS * ROW_BYTES;
  localparam int ENTRY_W    = 64;

  // Frame header bytes kept in flops: topic plus four argument bytes
  localparam int HDR_BYTES = 5;

  // Character codes
  localparam logic [7:0] CHAR_NL = 8'h0A;
  localparam logic [7:0] CHAR_0  = 8'h30;
  localparam logic [7:0] CHAR_9  = 8'h39;
  localparam logic [7:0] CHAR_8  = 8'h38;

  // Configuration register indexes
  localparam int         CFG_IDX_W       = 2;
  localparam logic [1:0] CFG_SPEED_TOPIC = 2'd0;
  localparam logic [1:0] CFG_STATE_TOPIC = 2'd1;
  localparam logic [1:0] CFG_WIFI_TOPIC  = 2'd2;

  // Request types
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  // Commands handed from the front end to the back end
  typedef enum logic [2:0] {
    CMD_BYTE  = 3'd0,  // byte stored, frame still open
    CMD_DONE  = 3'd1,  // frame closed with no effect
    CMD_SPEED = 3'd2,  // speed frame closed, arg = frame length
    CMD_STATE = 3'd3,  // state frame closed, arg = new machine state
    CMD_LINK  = 3'd4,  // wifi frame closed with connected pattern
    CMD_POP   = 3'd5   // pop oldest ring entry
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] arg;
  } cmd_t;

  typedef struct packed {
    logic                 valid;
    logic [CFG_IDX_W-1:0] index;
    logic [7:0]           data;
  } cfg_wr_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic        sample_valid;
    logic [15:0] speed_w0;
    logic [15:0] speed_w1;
    logic [15:0] speed_w2;
    logic [15:0] speed_w3;
    logic [4:0]  sample_count;
    logic [7:0]  machine_state;
    logic        link_connected;
    logic        frame_done;
  } out_t;

endpackage

[rtl/fsdr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module fsdr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/fsdr_front.sv]
// Front end: frame assembly, topic classification and command issue.
module fsdr_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  fsdr_pkg::in_t                item,
  input  fsdr_pkg::cfg_wr_t            cfg,
  input  logic                         q_full,
  input  logic                         speed_done,
  input  logic [fsdr_pkg::ROW_W-1:0]   stage_row,
  output logic                         busy,
  output logic                         q_push,
  output fsdr_pkg::cmd_t               q_cmd,
  output logic [fsdr_pkg::ENTRY_W-1:0] stage_data
);

  logic [7:0]                   frame_length;
  logic [7:0]                   hdr [fsdr_pkg::HDR_BYTES];
  logic [fsdr_pkg::ENTRY_W-1:0] row_acc;
  logic [fsdr_pkg::ENTRY_W-1:0] stage [fsdr_pkg::NUM_ROWS];
  logic [7:0]                   speed_topic;
  logic [7:0]                   state_topic;
  logic [7:0]                   wifi_topic;
  logic                         speed_hold;

  logic [7:0]                   hdr_next [fsdr_pkg::HDR_BYTES];
  logic [fsdr_pkg::ENTRY_W-1:0] acc_next;
  logic [7:0]                   pos_m1;
  logic                         in_span;
  logic [2:0]                   lane;
  logic [fsdr_pkg::ROW_W-1:0]   row;
  logic                         close;
  logic [7:0]                   topic;
  logic                         link_ok;
  logic                         accept_byte;

  // Hold off new transactions while the command queue is full or a speed copy reads the staging rows
  assign busy        = q_full || speed_hold;
  assign q_push      = start && !busy;
  assign accept_byte = q_push && (item.req_type == fsdr_pkg::REQ_BYTE);
  assign stage_data  = stage[stage_row];

  // Byte placement: header flops and the staging row for bytes 1..80
  always_comb begin
    pos_m1  = frame_length - 8'd1;
    in_span = (frame_length != 8'd0) && (frame_length <= 8'(fsdr_pkg::SPAN_BYTES));
    lane    = pos_m1[2:0];
    row     = pos_m1[3 +: fsdr_pkg::ROW_W];
    acc_next = row_acc;
    acc_next[{lane, 3'b000} +: 8] = item.rx_byte;
    for (int j = 0; j < fsdr_pkg::HDR_BYTES; j++) begin
      hdr_next[j] = (frame_length == 8'(j)) ? item.rx_byte : hdr[j];
    end
    close = (item.rx_byte == fsdr_pkg::CHAR_NL) ||
            (frame_length == 8'(fsdr_pkg::FRAME_BYTES - 1));
  end

  // Topic decode
  always_comb begin
    topic = hdr_next[0];
    if (topic >= fsdr_pkg::CHAR_0 && topic <= fsdr_pkg::CHAR_9) begin
      topic = topic - fsdr_pkg::CHAR_0;
    end
    link_ok = (hdr_next[1] == fsdr_pkg::CHAR_8) && (hdr_next[2] == fsdr_pkg::CHAR_8) &&
              (hdr_next[3] == fsdr_pkg::CHAR_8) && (hdr_next[4] == fsdr_pkg::CHAR_8);
  end

  // Command classification; speed beats state beats wifi on equal ids
  always_comb begin
    q_cmd.arg = 8'd0;
    priority if (item.req_type == fsdr_pkg::REQ_POP) begin
      q_cmd.kind = fsdr_pkg::CMD_POP;
    end else if (!close) begin
      q_cmd.kind = fsdr_pkg::CMD_BYTE;
    end else if (topic == speed_topic) begin
      q_cmd.kind = fsdr_pkg::CMD_SPEED;
      q_cmd.arg  = frame_length + 8'd1;
    end else if (topic == state_topic) begin
      q_cmd.kind = fsdr_pkg::CMD_STATE;
      q_cmd.arg  = hdr_next[1];
    end else if (topic == wifi_topic && link_ok) begin
      q_cmd.kind = fsdr_pkg::CMD_LINK;
    end else begin
      q_cmd.kind = fsdr_pkg::CMD_DONE;
    end
  end

  // Control state, topic registers and header bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length <= 8'd0;
      speed_topic  <= 8'd0;
      state_topic  <= 8'd1;
      wifi_topic   <= 8'd2;
      speed_hold   <= 1'b0;
      for (int j = 0; j < fsdr_pkg::HDR_BYTES; j++) begin
        hdr[j] <= 8'd0;
      end
    end else begin
      // Writes to an index with no register behind it are dropped
      if (cfg.valid) begin
        unique case (cfg.index)
          fsdr_pkg::CFG_SPEED_TOPIC: speed_topic <= cfg.data;
          fsdr_pkg::CFG_STATE_TOPIC: state_topic <= cfg.data;
          fsdr_pkg::CFG_WIFI_TOPIC:  wifi_topic  <= cfg.data;
          default: ;
        endcase
      end
      if (accept_byte) begin
        frame_length <= close ? 8'd0 : frame_length + 8'd1;
        for (int j = 0; j < fsdr_pkg::HDR_BYTES; j++) begin
          hdr[j] <= hdr_next[j];
        end
      end
      if (q_push && q_cmd.kind == fsdr_pkg::CMD_SPEED) begin
        speed_hold <= 1'b1;
      end else if (speed_done) begin
        speed_hold <= 1'b0;
      end
    end
  end

  // Staging rows: written when a row fills or the frame closes inside it
  always_ff @(posedge clk) begin
    if (accept_byte && in_span) begin
      row_acc <= acc_next;
      if (lane == 3'd7 || close) begin
        stage[row] <= acc_next;
      end
    end
  end

endmodule

[rtl/fsdr_cmd_fifo.sv]
// Two-entry command queue between the front end and the back end.
module fsdr_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  fsdr_pkg::cmd_t din,
  input  logic           pop,
  output fsdr_pkg::cmd_t dout,
  output logic           full,
  output logic           empty
);

  fsdr_pkg::cmd_t mem [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign dout  = mem[rd_ptr];

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

[rtl/fsdr_back.sv]
// Back end: speed store update, sample ring, machine state and result register.
module fsdr_back #(
  parameter int RING_DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_empty,
  input  fsdr_pkg::cmd_t               q_cmd,
  output logic                         q_pop,
  output logic [fsdr_pkg::ROW_W-1:0]   stage_row,
  input  logic [fsdr_pkg::ENTRY_W-1:0] stage_data,
  output logic                         speed_done,
  output fsdr_pkg::out_t               result,
  output logic                         strobe
);

  localparam int PW = $clog2(RING_DEPTH);
  localparam int FW = $clog2(RING_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_COPY = 3'b010,
    ST_POP  = 3'b100
  } state_t;

  state_t                       state;
  logic [fsdr_pkg::ROW_W-1:0]   g;
  logic [7:0]                   len;
  logic [fsdr_pkg::ENTRY_W-1:0] speed_row [fsdr_pkg::NUM_ROWS];
  logic [PW-1:0]                wr_pos;
  logic [PW-1:0]                rd_pos;
  logic [FW-1:0]                fill;
  logic [7:0]                   cur_state;
  logic                         connected;

  logic [7:0]                   take;
  logic [fsdr_pkg::ENTRY_W-1:0] merged;
  logic [fsdr_pkg::ENTRY_W-1:0] entry;
  logic [fsdr_pkg::ENTRY_W-1:0] ram_rdata;
  logic [PW-1:0]                wr_pos_next;
  logic [PW-1:0]                rd_pos_next;
  logic                         ring_full;
  logic [FW-1:0]                fill_push;
  logic                         last_row;

  assign q_pop      = (state == ST_IDLE) && !q_empty;
  assign stage_row  = g;
  assign last_row   = (g == fsdr_pkg::ROW_W'(fsdr_pkg::NUM_ROWS - 1));
  assign speed_done = (state == ST_COPY) && last_row;

  // Ring pointer arithmetic
  assign wr_pos_next = (wr_pos == PW'(RING_DEPTH - 1)) ? '0 : wr_pos + PW'(1);
  assign rd_pos_next = (rd_pos == PW'(RING_DEPTH - 1)) ? '0 : rd_pos + PW'(1);
  assign ring_full   = (fill == FW'(RING_DEPTH));
  assign fill_push   = ring_full ? fill : fill + FW'(1);

  // Row merge: frame bytes below the frame length replace speed store bytes
  always_comb begin
    for (int k = 0; k < fsdr_pkg::ROW_BYTES; k++) begin
      take[k] = (8'({g, 3'b000}) + 8'(k + 1)) < len;
      merged[8*k +: 8] = take[k] ? stage_data[8*k +: 8] : speed_row[g][8*k +: 8];
    end
    // Big-endian words, first word in the low bits
    for (int k = 0; k < 4; k++) begin
      entry[16*k +: 16] = {merged[16*k +: 8], merged[16*k+8 +: 8]};
    end
  end

  fsdr_ram #(
    .WIDTH (fsdr_pkg::ENTRY_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (state == ST_COPY),
    .waddr (wr_pos),
    .wdata (entry),
    .raddr (rd_pos),
    .rdata (ram_rdata)
  );

  // Command execution and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      g         <= '0;
      len       <= 8'd0;
      wr_pos    <= '0;
      rd_pos    <= '0;
      fill      <= '0;
      cur_state <= 8'd0;
      connected <= 1'b0;
      strobe    <= 1'b0;
      result    <= '0;
      for (int r = 0; r < fsdr_pkg::NUM_ROWS; r++) begin
        speed_row[r] <= '0;
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            // Status for commands that report at once
            result.sample_valid   <= 1'b0;
            result.speed_w0       <= 16'd0;
            result.speed_w1       <= 16'd0;
            result.speed_w2       <= 16'd0;
            result.speed_w3       <= 16'd0;
            result.sample_count   <= 5'(fill);
            result.machine_state  <= (q_cmd.kind == fsdr_pkg::CMD_STATE) ?
                                     q_cmd.arg : cur_state;
            result.link_connected <= connected || (q_cmd.kind == fsdr_pkg::CMD_LINK);
            result.frame_done     <= (q_cmd.kind == fsdr_pkg::CMD_DONE) ||
                                     (q_cmd.kind == fsdr_pkg::CMD_STATE) ||
                                     (q_cmd.kind == fsdr_pkg::CMD_LINK);
            unique case (q_cmd.kind)
              fsdr_pkg::CMD_STATE: begin
                strobe    <= 1'b1;
                cur_state <= q_cmd.arg;
              end
              fsdr_pkg::CMD_LINK: begin
                strobe    <= 1'b1;
                connected <= 1'b1;
              end
              fsdr_pkg::CMD_SPEED: begin
                strobe <= 1'b0;
                len    <= q_cmd.arg;
                g      <= '0;
                state  <= ST_COPY;
              end
              fsdr_pkg::CMD_POP: begin
                if (fill != '0) begin
                  strobe <= 1'b0;
                  rd_pos <= rd_pos_next;
                  fill   <= fill - FW'(1);
                  state  <= ST_POP;
                end else begin
                  strobe <= 1'b1;
                end
              end
              default: begin
                // plain byte or a close with no effect
                strobe <= 1'b1;
              end
            endcase
          end else begin
            strobe <= 1'b0;
          end
        end
        ST_COPY: begin
          // One ring push per row; a full ring drops its oldest entry
          strobe       <= last_row;
          speed_row[g] <= merged;
          wr_pos       <= wr_pos_next;
          fill         <= fill_push;
          if (ring_full) begin
            rd_pos <= rd_pos_next;
          end
          if (last_row) begin
            state                 <= ST_IDLE;
            result.sample_valid   <= 1'b0;
            result.speed_w0       <= 16'd0;
            result.speed_w1       <= 16'd0;
            result.speed_w2       <= 16'd0;
            result.speed_w3       <= 16'd0;
            result.sample_count   <= 5'(fill_push);
            result.machine_state  <= cur_state;
            result.link_connected <= connected;
            result.frame_done     <= 1'b1;
          end else begin
            g <= g + fsdr_pkg::ROW_W'(1);
          end
        end
        ST_POP: begin
          // Read data for the old read position is now registered
          state                 <= ST_IDLE;
          strobe                <= 1'b1;
          result.sample_valid   <= 1'b1;
          result.speed_w0       <= ram_rdata[15:0];
          result.speed_w1       <= ram_rdata[31:16];
          result.speed_w2       <= ram_rdata[47:32];
          result.speed_w3       <= ram_rdata[63:48];
          result.sample_count   <= 5'(fill);
          result.machine_state  <= cur_state;
          result.link_connected <= connected;
          result.frame_done     <= 1'b0;
        end
        default: begin
          state  <= ST_IDLE;
          strobe <= 1'b0;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(RING_DEPTH))
    else $error("ring fill above ring depth");

  a_pop_dec: assert property (@(posedge clk) disable iff (rst)
    state == ST_POP |-> fill == $past(fill) - FW'(1))
    else $error("pop read issued without a fill decrement");

  a_copy_rows: assert property (@(posedge clk) disable iff (rst)
    state == ST_COPY |-> g < fsdr_pkg::ROW_W'(fsdr_pkg::NUM_ROWS))
    else $error("speed copy row index out of range");

  a_valid_src: assert property (@(posedge clk) disable iff (rst)
    strobe && result.sample_valid |-> $past(state) == ST_POP)
    else $error("sample reported valid outside a pop read");

  a_speed_result: assert property (@(posedge clk) disable iff (rst)
    speed_done |=> strobe && result.frame_done)
    else $error("speed copy finished without a closing result");
`endif

endmodule

[rtl/frame_topic_dispatch_sample_ring_unit.sv]
// Top level: frame topic dispatcher with speed sample ring.
// A byte or non-speed frame close reports via the command queue and the result register;
// a pop adds the ring read state; a speed frame close makes ten ring writes through the
// single ring RAM write port. Bytes and non-speed closes go one per cycle when not busy,
// through a two-entry command queue; the back end pauses during a pop read. Busy stays
// high from a speed frame close until its ten pushes are done. Results cannot be stalled.
// Reset (rst, synchronous) clears the speed store and ring pointers and sets topic ids to 0, 1, 2 at once; no sweep.
module frame_topic_dispatch_sample_ring_unit #(
  parameter int RING_DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  fsdr_pkg::in_t                   item,
  output fsdr_pkg::out_t                  result,
  output logic                            strobe,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fsdr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                      cfg_data
);

  fsdr_pkg::cfg_wr_t            cfg_wr;
  fsdr_pkg::cmd_t               push_cmd;
  fsdr_pkg::cmd_t               head_cmd;
  logic                         q_push;
  logic                         q_pop;
  logic                         q_full;
  logic                         q_empty;
  logic                         speed_done;
  logic [fsdr_pkg::ROW_W-1:0]   stage_row;
  logic [fsdr_pkg::ENTRY_W-1:0] stage_data;

  // Register writes are always taken
  assign cfg_ready    = 1'b1;
  assign cfg_wr.valid = cfg_valid;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  fsdr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .item       (item),
    .cfg        (cfg_wr),
    .q_full     (q_full),
    .speed_done (speed_done),
    .stage_row  (stage_row),
    .busy       (busy),
    .q_push     (q_push),
    .q_cmd      (push_cmd),
    .stage_data (stage_data)
  );

  fsdr_cmd_fifo u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (push_cmd),
    .pop   (q_pop),
    .dout  (head_cmd),
    .full  (q_full),
    .empty (q_empty)
  );

  fsdr_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_cmd      (head_cmd),
    .q_pop      (q_pop),
    .stage_row  (stage_row),
    .stage_data (stage_data),
    .speed_done (speed_done),
    .result     (result),
    .strobe     (strobe)
  );

endmodule
